// File: hdl/mfr_pkg.sv
// ----------------------------------------------------------------------------
// MUSCL face reconstruction package
// Shared widths, datapath command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mfr_pkg;

	localparam int VAL_W      = 32;
	localparam int NVARS      = 3;
	localparam int PHI_FRAC   = 16;
	localparam int PHI_W      = PHI_FRAC + 2;
	localparam int DIV_STEPS  = PHI_W;
	localparam int IN_DATA_W  = NVARS * VAL_W;
	localparam int OUT_DATA_W = 2 * NVARS * VAL_W;

	localparam logic [PHI_W-1:0] PHI_ONE = PHI_W'(1) << PHI_FRAC;
	localparam logic [PHI_W-1:0] PHI_MAX = '1;

	// multiplier operand select
	localparam logic [2:0] MUL_NONE = 3'd0;
	localparam logic [2:0] MUL_AA   = 3'd1;
	localparam logic [2:0] MUL_AB   = 3'd2;
	localparam logic [2:0] MUL_BB   = 3'd3;
	localparam logic [2:0] MUL_HL   = 3'd4;
	localparam logic [2:0] MUL_HR   = 3'd5;

	typedef struct packed {
		logic       cap_in;
		logic       setup;
		logic [2:0] mul_sel;
		logic       aa_load;
		logic       num_load;
		logic       den_load;
		logic       div_step;
		logic       phi_load;
		logic       left_load;
		logic       right_load;
		logic       out_load;
		logic       out_first;
		logic       upd;
		logic [1:0] var_idx;
	} cmd_t;

	typedef struct packed {
		logic [1:0] count;
		logic       last;
		logic       out_free;
	} sts_t;

endpackage

// File: hdl/mfr_dp.sv
// ----------------------------------------------------------------------------
// MUSCL face reconstruction datapath
// Cell windows, shared multiplier, radix-2 limiter divider and output register.
// ----------------------------------------------------------------------------
module mfr_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [mfr_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                              s_tlast,
	input  mfr_pkg::cmd_t                     cmd,
	output mfr_pkg::sts_t                     sts,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [mfr_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tlast
);

	logic signed [31:0] w0_q [3];
	logic signed [31:0] w1_q [3];
	logic signed [31:0] w2_q [3];
	logic signed [31:0] x_q [3];
	logic signed [31:0] lft_q [3];
	logic signed [31:0] rgt_q [3];
	logic [17:0]        held_q [3];
	logic [17:0]        phi_q [3];
	logic [1:0]         count_q;
	logic               last_q;

	logic [32:0]        a_q, b_q;
	logic               dz_q, zr_q;
	logic signed [67:0] prod_q;
	logic [65:0]        aa_q, num_q, den_q;
	logic [67:0]        r_q;
	logic [17:0]        q_q;
	logic               m_tvalid_q, m_tlast_q;
	logic [mfr_pkg::OUT_DATA_W-1:0] m_tdata_q;

	logic [1:0]         v;
	logic signed [32:0] d_c, n_c, dl_c, dr_c;
	logic signed [33:0] ma, mb;
	logic [67:0]        dd_c;
	logic [68:0]        t_c;
	logic               ge_c, sat_c;
	logic signed [51:0] slope_c, lsum_c, rsum_c;

	function automatic logic signed [31:0] sat32(input logic signed [51:0] s);
		logic signed [51:0] top, bot;
		top = 52'sd2147483647;
		bot = -52'sd2147483648;
		if (s > top) begin
			sat32 = 32'sh7fffffff;
		end else if (s < bot) begin
			sat32 = 32'sh80000000;
		end else begin
			sat32 = s[31:0];
		end
	endfunction

	assign v = cmd.var_idx;

	always_comb begin
		d_c  = {w2_q[v][31], w2_q[v]} - {w1_q[v][31], w1_q[v]};
		n_c  = {x_q[v][31], x_q[v]} - {w2_q[v][31], w2_q[v]};
		dl_c = {w1_q[v][31], w1_q[v]} - {w0_q[v][31], w0_q[v]};
		dr_c = d_c;
	end

	always_comb begin
		unique case (cmd.mul_sel)
			mfr_pkg::MUL_AA: begin
				ma = {1'b0, a_q};
				mb = {1'b0, a_q};
			end
			mfr_pkg::MUL_AB: begin
				ma = {1'b0, a_q};
				mb = {1'b0, b_q};
			end
			mfr_pkg::MUL_BB: begin
				ma = {1'b0, b_q};
				mb = {1'b0, b_q};
			end
			mfr_pkg::MUL_HL: begin
				ma = {16'b0, held_q[v]};
				mb = {dl_c[32], dl_c};
			end
			mfr_pkg::MUL_HR: begin
				ma = {16'b0, phi_q[v]};
				mb = {dr_c[32], dr_c};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// one quotient bit per step against 4*den
	always_comb begin
		dd_c    = {den_q, 2'b00};
		t_c     = {r_q, 1'b0};
		ge_c    = t_c >= {1'b0, dd_c};
		sat_c   = {2'b00, num_q} >= dd_c;
		slope_c = {prod_q[67], prod_q[67:17]};
		lsum_c  = 52'(w1_q[v]) + slope_c;
		rsum_c  = 52'(w2_q[v]) - slope_c;
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		if (cmd.cap_in) begin
			for (int i = 0; i < mfr_pkg::NVARS; i++) begin
				x_q[i] <= s_tdata[i*mfr_pkg::VAL_W +: mfr_pkg::VAL_W];
			end
			last_q <= s_tlast;
		end
		if (cmd.setup) begin
			a_q  <= n_c[32] ? 33'(-n_c) : 33'(n_c);
			b_q  <= d_c[32] ? 33'(-d_c) : 33'(d_c);
			dz_q <= d_c == '0;
			zr_q <= (n_c == '0) || (n_c[32] != d_c[32]);
		end
		if (cmd.aa_load) begin
			aa_q <= prod_q[65:0];
		end
		if (cmd.num_load) begin
			num_q <= aa_q + prod_q[65:0];
		end
		if (cmd.den_load) begin
			den_q <= aa_q + prod_q[65:0];
			r_q   <= {2'b00, num_q};
			q_q   <= '0;
		end
		if (cmd.div_step) begin
			if (ge_c) begin
				r_q <= 68'(t_c - {1'b0, dd_c});
				q_q <= {q_q[16:0], 1'b1};
			end else begin
				r_q <= 68'(t_c);
				q_q <= {q_q[16:0], 1'b0};
			end
		end
		if (cmd.phi_load) begin
			if (dz_q) begin
				phi_q[v] <= mfr_pkg::PHI_ONE;
			end else if (zr_q) begin
				phi_q[v] <= '0;
			end else if (sat_c) begin
				phi_q[v] <= mfr_pkg::PHI_MAX;
			end else begin
				phi_q[v] <= q_q;
			end
		end
		if (cmd.left_load) begin
			lft_q[v] <= sat32(lsum_c);
		end
		if (cmd.right_load) begin
			rgt_q[v] <= sat32(rsum_c);
		end
		if (cmd.out_load) begin
			for (int i = 0; i < mfr_pkg::NVARS; i++) begin
				m_tdata_q[2*i*mfr_pkg::VAL_W +: mfr_pkg::VAL_W] <=
					cmd.out_first ? w2_q[i] : lft_q[i];
				m_tdata_q[(2*i+1)*mfr_pkg::VAL_W +: mfr_pkg::VAL_W] <=
					cmd.out_first ? x_q[i] : rgt_q[i];
			end
			m_tlast_q <= cmd.out_first & last_q;
		end
	end

	// row state: windows, held limiters, cell count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mfr_pkg::NVARS; i++) begin
				w0_q[i]   <= '0;
				w1_q[i]   <= '0;
				w2_q[i]   <= '0;
				held_q[i] <= '0;
			end
			count_q <= '0;
		end else if (cmd.upd) begin
			if (last_q) begin
				for (int i = 0; i < mfr_pkg::NVARS; i++) begin
					w0_q[i]   <= '0;
					w1_q[i]   <= '0;
					w2_q[i]   <= '0;
					held_q[i] <= '0;
				end
				count_q <= '0;
			end else begin
				for (int i = 0; i < mfr_pkg::NVARS; i++) begin
					w0_q[i] <= w1_q[i];
					w1_q[i] <= w2_q[i];
					w2_q[i] <= x_q[i];
					if (count_q >= 2'd2) begin
						held_q[i] <= phi_q[i];
					end
				end
				count_q <= (count_q == 2'd3) ? 2'd3 : 2'(count_q + 2'd1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid     = m_tvalid_q;
	assign m_tdata      = m_tdata_q;
	assign m_tlast      = m_tlast_q;
	assign sts.count    = count_q;
	assign sts.last     = last_q;
	assign sts.out_free = !m_tvalid_q || m_tready;

endmodule

// File: hdl/mfr_ctrl.sv
// ----------------------------------------------------------------------------
// MUSCL face reconstruction controller
// Sequences limiter, slope and face output steps for each accepted cell.
// ----------------------------------------------------------------------------
module mfr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  mfr_pkg::sts_t sts,
	output mfr_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SETUP = 4'd1;
	localparam logic [3:0] S_MAA   = 4'd2;
	localparam logic [3:0] S_MAB   = 4'd3;
	localparam logic [3:0] S_MBB   = 4'd4;
	localparam logic [3:0] S_DEN   = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_PHI   = 4'd7;
	localparam logic [3:0] S_HL    = 4'd8;
	localparam logic [3:0] S_HR    = 4'd9;
	localparam logic [3:0] S_HR2   = 4'd10;
	localparam logic [3:0] S_OUT2  = 4'd11;
	localparam logic [3:0] S_OUT1  = 4'd12;
	localparam logic [3:0] S_UPD   = 4'd13;

	localparam logic [4:0] DIV_LAST = 5'(mfr_pkg::DIV_STEPS - 1);
	localparam logic [1:0] VAR_LAST = 2'(mfr_pkg::NVARS - 1);

	logic [3:0] state_q;
	logic [1:0] var_q;
	logic [4:0] step_q;
	logic       need_first;

	assign need_first = (sts.last && sts.count != 2'd0) || sts.count == 2'd1;

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = mfr_pkg::MUL_NONE;
		cmd.var_idx = var_q;
		s_tready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready   = 1'b1;
				cmd.cap_in = s_tvalid;
			end
			S_SETUP: cmd.setup = 1'b1;
			S_MAA:   cmd.mul_sel = mfr_pkg::MUL_AA;
			S_MAB: begin
				cmd.mul_sel = mfr_pkg::MUL_AB;
				cmd.aa_load = 1'b1;
			end
			S_MBB: begin
				cmd.mul_sel  = mfr_pkg::MUL_BB;
				cmd.num_load = 1'b1;
			end
			S_DEN:   cmd.den_load = 1'b1;
			S_DIV:   cmd.div_step = 1'b1;
			S_PHI:   cmd.phi_load = 1'b1;
			S_HL:    cmd.mul_sel = mfr_pkg::MUL_HL;
			S_HR: begin
				cmd.mul_sel   = mfr_pkg::MUL_HR;
				cmd.left_load = 1'b1;
			end
			S_HR2:   cmd.right_load = 1'b1;
			S_OUT2:  cmd.out_load = sts.out_free;
			S_OUT1: begin
				cmd.out_load  = need_first && sts.out_free;
				cmd.out_first = 1'b1;
			end
			S_UPD:   cmd.upd = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			var_q   <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					var_q <= '0;
					if (s_tvalid) begin
						state_q <= (sts.count >= 2'd2) ? S_SETUP : S_OUT1;
					end
				end
				S_SETUP: state_q <= S_MAA;
				S_MAA:   state_q <= S_MAB;
				S_MAB:   state_q <= S_MBB;
				S_MBB:   state_q <= S_DEN;
				S_DEN: begin
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (step_q == DIV_LAST) begin
						state_q <= S_PHI;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				S_PHI: begin
					if (sts.count == 2'd3) begin
						state_q <= S_HL;
					end else if (var_q == VAR_LAST) begin
						state_q <= S_OUT1;
					end else begin
						var_q   <= var_q + 2'd1;
						state_q <= S_SETUP;
					end
				end
				S_HL: state_q <= S_HR;
				S_HR: state_q <= S_HR2;
				S_HR2: begin
					if (var_q == VAR_LAST) begin
						state_q <= S_OUT2;
					end else begin
						var_q   <= var_q + 2'd1;
						state_q <= S_SETUP;
					end
				end
				S_OUT2: begin
					if (sts.out_free) begin
						state_q <= S_OUT1;
					end
				end
				S_OUT1: begin
					if (!need_first || sts.out_free) begin
						state_q <= S_UPD;
					end
				end
				S_UPD:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/muscl_face_reconstruction_unit.sv
// Sequence: a cell with fewer than two predecessors goes from request through output to update;
// otherwise each variable runs setup, the multiplies, the den load, the radix-2 divider loop and phi,
// plus the slope steps once the window is full, then the face output steps, which wait under stall.
// Throughput: one cell at a time, set by the shared multiplier and radix-2 divider loop.
// Reset: arst_n clears the cell windows, held limiters, cell count and output valid.
// ----------------------------------------------------------------------------
// MUSCL face reconstruction unit
// Streams 1D cells in and limited left/right face states out.
// ----------------------------------------------------------------------------
module muscl_face_reconstruction_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mfr_pkg::IN_DATA_W-1:0]  s_tdata,  // pressure, velocity, density
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// pressure_left, pressure_right, velocity_left, velocity_right,
	// density_left, density_right
	output logic [mfr_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tlast
);

	mfr_pkg::cmd_t cmd;
	mfr_pkg::sts_t sts;

	mfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mfr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.cmd      (cmd),
		.sts      (sts),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// File: hdl/mfr_checker.sv
// ----------------------------------------------------------------------------
// MUSCL face reconstruction checker
// Port-level properties of the reconstruction unit, bound to the top level.
// ----------------------------------------------------------------------------
module mfr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [mfr_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           m_tlast
);

	// one cell in flight: no acceptance right after an accepted one
	a_one_cell: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted twice in a row");

	// a new face appears only while the cell is still being worked
	a_face_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !s_tready)
		else $error("face raised while idle");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output valid dropped under stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output payload changed under stall");

endmodule

bind muscl_face_reconstruction_unit mfr_checker u_mfr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
